/* src/determinant_excitation_phase_assert.svh */
// Assertion macros used by the RTL file of the excitation phase block.
`ifndef DETERMINANT_EXCITATION_PHASE_ASSERT_SVH
`define DETERMINANT_EXCITATION_PHASE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DEP_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define DEP_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

/* src/dep_pkg.sv */
package dep_pkg;

  localparam int ORBITALS_DEFAULT = 32;
  localparam int CFG_W            = 6;
  localparam int STR_W            = 32;
  localparam int ORB_W            = 5;

  localparam logic [CFG_W-1:0] ORB_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic [STR_W-1:0] ref_alpha;
    logic [STR_W-1:0] ref_beta;
    logic [STR_W-1:0] exc_alpha;
    logic [STR_W-1:0] exc_beta;
  } in_t;

  typedef struct packed {
    logic             pair_valid;
    logic             spin_beta;
    logic [ORB_W-1:0] hole_orbital;
    logic [ORB_W-1:0] particle_orbital;
    logic             sign_negative;
    logic             count_mismatch;
    logic             last;
  } out_t;

endpackage

/* src/determinant_excitation_phase.sv */
// Sequence: after the input beat, a bit-serial scan of the n orbitals (n = clamped
// orbital_count), then a pointer walk per spin string, then the flush of the last result beat.
// One item at a time: a new item is taken only once the last one is flushed, and
// result-side stalls hold both the pointer walk and the flush.
// Reset: rst is synchronous, active high; it idles the sequencer, empties the result
// register and sets orbital_count to 32.
module determinant_excitation_phase #(
  parameter int ORBITALS = dep_pkg::ORBITALS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [dep_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  dep_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dep_pkg::out_t            out_data
);

  localparam int IDX_W  = (ORBITALS > 1) ? $clog2(ORBITALS) : 1;
  localparam int PTR_W  = $clog2(ORBITALS + 1);
  localparam int DIFF_W = PTR_W + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_PAIR  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]                state;
  logic [dep_pkg::CFG_W-1:0] orbital_count;
  logic [PTR_W-1:0]          n_use;
  logic [PTR_W-1:0]          n_clamp;

  logic [ORBITALS-1:0] ref_a, ref_b, exc_a, exc_b;
  logic [ORBITALS-1:0] pfx_a, pfx_b;
  logic                par_a, par_b;
  logic [DIFF_W-1:0]   diff_a, diff_b;
  logic [PTR_W-1:0]    scan_ptr, hptr, pptr;
  logic                spin;
  logic                sign;
  logic                pend_valid;
  dep_pkg::out_t       pend;

  logic [ORBITALS-1:0] cur_ref, cur_exc, cur_pfx, flip;
  logic [IDX_W-1:0]    sidx, hidx, pidx;
  logic                h_in, p_in, at_h, at_p, spin_done;
  logic                out_free, pair_go, push, sign_new, mismatch;
  dep_pkg::out_t       push_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign mismatch  = (diff_a != '0) || (diff_b != '0);

  always_comb begin
    if (orbital_count == '0) begin
      n_clamp = PTR_W'(1);
    end else if (orbital_count > dep_pkg::CFG_W'(ORBITALS)) begin
      n_clamp = PTR_W'(ORBITALS);
    end else begin
      n_clamp = PTR_W'(orbital_count);
    end
  end

  always_comb begin
    cur_ref   = spin ? ref_b : ref_a;
    cur_exc   = spin ? exc_b : exc_a;
    cur_pfx   = spin ? pfx_b : pfx_a;
    sidx      = scan_ptr[IDX_W-1:0];
    hidx      = hptr[IDX_W-1:0];
    pidx      = pptr[IDX_W-1:0];
    h_in      = hptr < n_use;
    p_in      = pptr < n_use;
    at_h      = h_in && cur_ref[hidx] && !cur_exc[hidx];
    at_p      = p_in && cur_exc[pidx] && !cur_ref[pidx];
    spin_done = !h_in || !p_in;
    pair_go   = (state == ST_PAIR) && !spin_done && at_h && at_p
                && (!pend_valid || out_free);
    // Annihilate then create: prefix parity at the hole, then at the particle
    // with the hole already gone.
    sign_new  = sign ^ cur_pfx[hidx] ^ cur_pfx[pidx] ^ (pptr > hptr);
    for (int i = 0; i < ORBITALS; i++) begin
      flip[i] = (PTR_W'(i) > hptr) ^ (PTR_W'(i) > pptr);
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = pend;
    if (pair_go && pend_valid) begin
      push = 1'b1;
    end
    if (state == ST_FLUSH && out_free) begin
      push = 1'b1;
      if (pend_valid) begin
        push_data.last = 1'b1;
      end else begin
        push_data                = '0;
        push_data.count_mismatch = mismatch;
        push_data.last           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orbital_count <= dep_pkg::ORB_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      orbital_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (push) begin
      out_data <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ref_a      <= in_data.ref_alpha[ORBITALS-1:0];
            ref_b      <= in_data.ref_beta[ORBITALS-1:0];
            exc_a      <= in_data.exc_alpha[ORBITALS-1:0];
            exc_b      <= in_data.exc_beta[ORBITALS-1:0];
            n_use      <= n_clamp;
            scan_ptr   <= '0;
            par_a      <= 1'b0;
            par_b      <= 1'b0;
            diff_a     <= '0;
            diff_b     <= '0;
            sign       <= 1'b0;
            pend_valid <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pfx_a[sidx] <= par_a;
          pfx_b[sidx] <= par_b;
          par_a       <= par_a ^ ref_a[sidx];
          par_b       <= par_b ^ ref_b[sidx];
          diff_a      <= diff_a + DIFF_W'(ref_a[sidx]) - DIFF_W'(exc_a[sidx]);
          diff_b      <= diff_b + DIFF_W'(ref_b[sidx]) - DIFF_W'(exc_b[sidx]);
          scan_ptr    <= scan_ptr + PTR_W'(1);
          if (scan_ptr + PTR_W'(1) == n_use) begin
            hptr  <= '0;
            pptr  <= '0;
            spin  <= 1'b0;
            state <= ST_PAIR;
          end
        end
        ST_PAIR: begin
          if (spin_done) begin
            if (!spin) begin
              spin <= 1'b1;
              hptr <= '0;
              pptr <= '0;
            end else begin
              state <= ST_FLUSH;
            end
          end else if (at_h && at_p) begin
            if (pair_go) begin
              hptr       <= hptr + PTR_W'(1);
              pptr       <= pptr + PTR_W'(1);
              sign       <= sign_new;
              pend_valid <= 1'b1;
              pend.pair_valid       <= 1'b1;
              pend.spin_beta        <= spin;
              pend.hole_orbital     <= dep_pkg::ORB_W'(hptr);
              pend.particle_orbital <= dep_pkg::ORB_W'(pptr);
              pend.sign_negative    <= sign_new;
              pend.count_mismatch   <= mismatch;
              pend.last             <= 1'b0;
              if (spin) begin
                pfx_b <= pfx_b ^ flip;
              end else begin
                pfx_a <= pfx_a ^ flip;
              end
            end
          end else begin
            // Advance whichever pointer is not yet parked on its target.
            if (!at_h) begin
              hptr <= hptr + PTR_W'(1);
            end
            if (!at_p) begin
              pptr <= pptr + PTR_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "determinant_excitation_phase_assert.svh"

  `DEP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `DEP_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.pair_valid, out_data.last)
  `DEP_ASSERT_NOW(a_idle_out_last, state == ST_IDLE && out_valid, out_data.last)
  `DEP_ASSERT_NOW(a_ptr_bound, state == ST_PAIR, hptr <= n_use && pptr <= n_use)

endmodule

/* verif/tb_top.sv */
module tb_top;

  localparam int ORBITALS    = dep_pkg::ORBITALS_DEFAULT;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 200;
  localparam int CHAIN_ITEMS = 31;

  typedef struct packed {
    dep_pkg::in_t  item;
    logic          typed;
    dep_pkg::out_t result;
  } probe_t;

  localparam dep_pkg::out_t NOT_TYPED      = '0;
  localparam dep_pkg::out_t EMPTY_MATCH    = '{1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b1};
  localparam dep_pkg::out_t EMPTY_MISMATCH = '{1'b0, 1'b0, 5'd0, 5'd0, 1'b0, 1'b1, 1'b1};

  // Runs at the reset orbital count of 32.
  localparam probe_t DIRECTED [17] = '{
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, EMPTY_MATCH},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, EMPTY_MATCH},
    '{'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1, EMPTY_MISMATCH},
    '{'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, EMPTY_MISMATCH},
    '{'{32'h0000_000F, 32'h0000_0000, 32'h0000_0000, 32'h0000_000F}, 1'b1, EMPTY_MISMATCH},
    '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0003, 32'h0000_0000}, 1'b1, EMPTY_MISMATCH},
    '{'{32'h0000_0001, 32'h0000_0000, 32'h0000_0002, 32'h0000_0000}, 1'b1,
      '{1'b1, 1'b0, 5'd0, 5'd1, 1'b0, 1'b0, 1'b1}},
    '{'{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0002}, 1'b1,
      '{1'b1, 1'b1, 5'd0, 5'd1, 1'b0, 1'b0, 1'b1}},
    '{'{32'h8000_0000, 32'h0000_0000, 32'h4000_0000, 32'h0000_0000}, 1'b1,
      '{1'b1, 1'b0, 5'd31, 5'd30, 1'b0, 1'b0, 1'b1}},
    '{'{32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0000_FFFF}, 1'b0, NOT_TYPED},
    '{'{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, NOT_TYPED},
    '{'{32'h0000_0003, 32'h8000_0001, 32'h0000_0005, 32'h8000_0001}, 1'b0, NOT_TYPED},
    '{'{32'h0000_0007, 32'h0000_0000, 32'h0000_0030, 32'h0000_0000}, 1'b0, NOT_TYPED},
    '{'{32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001}, 1'b0, NOT_TYPED},
    '{'{32'h1234_5678, 32'h0F0F_0F0F, 32'h1234_5678, 32'hF0F0_F0F0}, 1'b0, NOT_TYPED},
    '{'{32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, NOT_TYPED},
    '{'{32'hDEAD_BEEF, 32'h0123_4567, 32'hCAFE_F00D, 32'h89AB_CDEF}, 1'b0, NOT_TYPED}
  };

  // Orbital count written before each later stretch of random items; the last one runs calm.
  localparam logic [dep_pkg::CFG_W-1:0] COUNT_STEPS [8] = '{
    6'd1, 6'd0, 6'd63, 6'd5, 6'd33, 6'd17, 6'd2, 6'd32
  };

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [dep_pkg::CFG_W-1:0] cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  dep_pkg::in_t              in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  dep_pkg::out_t             out_data;

  logic [dep_pkg::CFG_W-1:0] orbital_count_reg = dep_pkg::ORB_COUNT_RESET;
  dep_pkg::out_t             expected_pairs[$];
  bit               calm          = 1'b0;
  bit               long_hold_req = 1'b0;
  int               rx_hold       = 0;
  int               quiet_cycles  = 0;
  int               bad_results   = 0;
  int               items_sent    = 0;
  int               results_seen  = 0;
  int               negative_seen = 0;
  int               empty_seen    = 0;
  int               settings_used = 1;

  determinant_excitation_phase #(
    .ORBITALS(ORBITALS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned effective_orbitals(input logic [dep_pkg::CFG_W-1:0] count);
    if (count < 1) return 1;
    if (count > ORBITALS) return ORBITALS;
    return count;
  endfunction

  function automatic int unsigned lowest_set(input logic [31:0] v);
    for (int i = 0; i < 32; i++) if (v[i]) return i;
    return 31;
  endfunction

  // Pair holes with particles per spin, alpha first, and track the phase on a working copy.
  function automatic void predict_excitations(input dep_pkg::in_t d,
                                              input logic [dep_pkg::CFG_W-1:0] count);
    int unsigned   n, base, h, p, produced;
    logic [31:0]   keep, holes, parts;
    logic [31:0]   occ_ref [2];
    logic [31:0]   occ_exc [2];
    logic [63:0]   occ_work;
    logic          sign, mism;
    dep_pkg::out_t r;
    n = effective_orbitals(count);
    keep = 32'((64'd1 << n) - 64'd1);
    occ_ref[0] = d.ref_alpha & keep;
    occ_ref[1] = d.ref_beta & keep;
    occ_exc[0] = d.exc_alpha & keep;
    occ_exc[1] = d.exc_beta & keep;
    mism = ($countones(occ_ref[0]) != $countones(occ_exc[0])) ||
           ($countones(occ_ref[1]) != $countones(occ_exc[1]));
    occ_work = {32'b0, occ_ref[0]} | (64'(occ_ref[1]) << n);
    sign = 1'b0;
    produced = 0;
    for (int s = 0; s < 2; s++) begin
      holes = occ_ref[s] & ~occ_exc[s];
      parts = occ_exc[s] & ~occ_ref[s];
      base = (s == 1) ? n : 0;
      while (holes != 0 && parts != 0) begin
        h = lowest_set(holes);
        p = lowest_set(parts);
        holes &= holes - 1;
        parts &= parts - 1;
        // annihilate, then create; each flips on the parity of what lies below
        occ_work[base + h] = 1'b0;
        sign ^= ^(occ_work & ((64'd1 << (base + h)) - 64'd1));
        occ_work[base + p] = 1'b1;
        sign ^= ^(occ_work & ((64'd1 << (base + p)) - 64'd1));
        r = '{1'b1, s[0], h[4:0], p[4:0], sign, mism, 1'b0};
        expected_pairs = {expected_pairs, r};
        produced++;
      end
    end
    if (produced == 0) begin
      r = '{1'b0, 1'b0, 5'd0, 5'd0, 1'b0, mism, 1'b1};
      expected_pairs = {expected_pairs, r};
    end else begin
      r = expected_pairs.pop_back();
      r.last = 1'b1;
      expected_pairs = {expected_pairs, r};
    end
  endfunction

  // Mostly equal-count excitations with random content, some identical pairs, some noise.
  function automatic dep_pkg::in_t draw_item(input int unsigned n);
    dep_pkg::in_t d;
    logic [31:0]  keep, e;
    int unsigned  pick, h, p;
    keep = 32'((64'd1 << n) - 64'd1);
    d.ref_alpha = $urandom;
    d.ref_beta = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 25) begin
      d.exc_alpha = $urandom;
      d.exc_beta = $urandom;
    end else begin
      for (int s = 0; s < 2; s++) begin
        e = (s == 1) ? d.ref_beta : d.ref_alpha;
        if (pick >= 40) begin
          repeat ($urandom_range(8, 0)) begin
            h = $urandom_range(n - 1, 0);
            p = $urandom_range(n - 1, 0);
            if (e[h] && !e[p]) begin
              e[h] = 1'b0;
              e[p] = 1'b1;
            end
          end
        end
        // junk above the orbital count must be ignored
        e = (e & keep) | ($urandom & ~keep);
        if (s == 0) d.exc_alpha = e;
        else d.exc_beta = e;
      end
    end
    return d;
  endfunction

  task automatic send_item(input dep_pkg::in_t d, input logic typed,
                           input dep_pkg::out_t typed_result, input bit drain_first);
    if (drain_first) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (expected_pairs.size() != 0);
    end else if (!calm && $urandom_range(3, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) expected_pairs = {expected_pairs, typed_result};
    else predict_excitations(d, orbital_count_reg);
    items_sent++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++)
      send_item(draw_item(effective_orbitals(orbital_count_reg)), 1'b0, NOT_TYPED, i == 15);
  endtask

  task automatic write_orbital_count(input logic [dep_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    orbital_count_reg = value;
    settings_used++;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].result, 1'b0);
    // keep offering items while the result side holds off
    long_hold_req = 1'b1;
    run_random(40);
    foreach (COUNT_STEPS[k]) begin
      in_valid <= 1'b0;
      while (expected_pairs.size() != 0) @(posedge clk);
      if (k == $size(COUNT_STEPS) - 1) calm = 1'b1;
      write_orbital_count(COUNT_STEPS[k]);
      run_random(CHAIN_ITEMS);
    end
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_pairs.size() != 0) bad_results++;
    $display("%0d determinant pairs over %0d orbital-count settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("%0d results with negative phase, %0d without any pair, %0d failures",
             negative_seen, empty_seen, bad_results);
    if (bad_results == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: short random stalls, one long hold on request, none at the end.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_ready <= 1'b0;
      rx_hold <= LONG_HOLD - 1;
    end else if (!calm && $urandom_range(4, 0) == 0) begin
      out_ready <= 1'b0;
      rx_hold <= $urandom_range(3, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    dep_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.sign_negative) negative_seen++;
      if (!out_data.pair_valid) empty_seen++;
      if (expected_pairs.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected beat: %p", out_data);
      end else begin
        want = expected_pairs.pop_front();
        if (out_data.pair_valid !== want.pair_valid ||
            out_data.spin_beta !== want.spin_beta ||
            out_data.hole_orbital !== want.hole_orbital ||
            out_data.particle_orbital !== want.particle_orbital ||
            out_data.sign_negative !== want.sign_negative ||
            out_data.count_mismatch !== want.count_mismatch ||
            out_data.last !== want.last) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("beat %0d expected valid=%0b beta=%0b hole=%0d part=%0d neg=%0b",
                     results_seen, want.pair_valid, want.spin_beta, want.hole_orbital,
                     want.particle_orbital, want.sign_negative);
            $display("  expected mis=%0b last=%0b", want.count_mismatch, want.last);
            $display("beat %0d actual   valid=%0b beta=%0b hole=%0d part=%0d neg=%0b",
                     results_seen, out_data.pair_valid, out_data.spin_beta,
                     out_data.hole_orbital, out_data.particle_orbital,
                     out_data.sign_negative);
            $display("  actual   mis=%0b last=%0b", out_data.count_mismatch, out_data.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding", QUIET_LIMIT,
               expected_pairs.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
